// File: rtl/seed_window_table_top_assert.svh
// Assertion macros for the seed window table.
// Expects clk and rst_n in the scope of use.
`ifndef SEED_WINDOW_TABLE_TOP_ASSERT_SVH
`define SEED_WINDOW_TABLE_TOP_ASSERT_SVH

// condition in the same cycle
`define SWT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition in the following cycle
`define SWT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/swt_pkg.sv
// Shared types, codes and defaults of the seed window table.
// Used by the RAM-based datapath, the controller and the top level.
package swt_pkg;

    localparam int NUM_WINDOWS_DEF = 16;
    localparam int SLOTS_DEF       = 64;
    localparam logic [6:0] MAX_PER_WINDOW_RESET = 7'd50;

    localparam logic [1:0] MODE_NEW    = 2'd0;
    localparam logic [1:0] MODE_ASSIGN = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    localparam logic [2:0] ST_ACK   = 3'd0;
    localparam logic [2:0] ST_NOWIN = 3'd1;
    localparam logic [2:0] ST_SHORT = 3'd2;
    localparam logic [2:0] ST_REPL  = 3'd3;
    localparam logic [2:0] ST_KEPT  = 3'd4;
    localparam logic [2:0] ST_INS   = 3'd5;
    localparam logic [2:0] ST_ABORT = 3'd6;
    localparam logic [2:0] ST_ERROR = 3'd7;

    typedef struct packed {
        logic [39:0] gs;
        logic [15:0] sj;
        logic        frag;
        logic        anc;
        logic [15:0] rep;
        logic [9:0]  rs;
        logic [9:0]  len;
    } entry_t;

    typedef enum logic [2:0] {
        IDX_HOLD, IDX_ZERO, IDX_INC, IDX_DEC, IDX_CNT, IDX_HIT
    } idx_op_t;

    typedef enum logic [1:0] {INS_HOLD, INS_IDX, INS_CNT, INS_ADJ} ins_op_t;

    typedef enum logic [1:0] {MIN_HOLD, MIN_INIT, MIN_UPD} min_op_t;

    typedef enum logic [2:0] {
        ADDR_IDX, ADDR_IDX_DN, ADDR_IDX_UP, ADDR_INS, ADDR_KEEP, ADDR_SLOT
    } addr_sel_t;

    typedef enum logic {WD_RDATA, WD_NEW} wd_sel_t;

    typedef enum logic [1:0] {POS_NONE, POS_SLOT, POS_HIT, POS_INS} pos_sel_t;

    typedef struct packed {
        logic       load;
        logic       clear_all;
        idx_op_t    idx_op;
        logic       mem_re;
        addr_sel_t  addr_sel;
        logic       mem_we;
        wd_sel_t    wd_sel;
        logic       hit_set;
        ins_op_t    ins_op;
        min_op_t    min_op;
        logic       min_commit;
        logic       set_abort;
        logic       compact_step;
        logic       keep_zero;
        logic       keep_commit;
        logic       insert_commit;
        logic       finish;
        logic [2:0] fin_status;
        pos_sel_t   pos_sel;
        logic       fin_entry;
        logic       fin_fill;
    } cmd_t;

    typedef struct packed {
        logic mode_new;
        logic mode_assign;
        logic mode_read;
        logic w_valid;
        logic slot_out;
        logic aborted;
        logic too_short;
        logic cnt_zero;
        logic idx_last;
        logic match;
        logic longer;
        logic ins_found;
        logic rs_less;
        logic full;
        logic min_none;
        logic short_new;
        logic insert_ok;
        logic at_limit;
        logic k_gt_ins;
        logic k_lt_ins;
    } sts_t;

endpackage

// File: rtl/swt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module swt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/swt_datapath.sv
// Datapath: entry RAM, per-window state, scan counters and result words.
// Depends on swt_pkg and swt_ram; driven by swt_ctrl commands.
module swt_datapath
    import swt_pkg::*;
#(
    parameter int NUM_WINDOWS = NUM_WINDOWS_DEF,
    parameter int SLOTS       = SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        cmd,
    output sts_t        sts,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    input  logic [1:0]  mode,
    input  logic [4:0]  window_index,
    input  logic [39:0] genome_start,
    input  logic [9:0]  align_length,
    input  logic [9:0]  read_start,
    input  logic [15:0] repeat_count,
    input  logic        is_anchor,
    input  logic        fragment,
    input  logic [15:0] junction_id,
    input  logic [9:0]  read_length,
    input  logic [5:0]  slot,
    output logic        done,
    output logic [2:0]  status,
    output logic [5:0]  position,
    output logic [6:0]  entry_count,
    output logic [7:0]  piece_count,
    output logic [5:0]  last_anchor,
    output logic [39:0] entry_genome_start,
    output logic [9:0]  entry_length,
    output logic [9:0]  entry_read_start,
    output logic [15:0] entry_repeats,
    output logic        entry_anchor,
    output logic        entry_fragment,
    output logic [15:0] entry_junction
);

    localparam int AW = $clog2(NUM_WINDOWS * SLOTS);
    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam int WW = (NUM_WINDOWS > 1) ? $clog2(NUM_WINDOWS) : 1;
    localparam int EW = $bits(entry_t);

    logic [1:0]  mode_reg;
    logic [4:0]  win_reg;
    logic [39:0] gs_reg;
    logic [9:0]  len_reg;
    logic [9:0]  rs_reg;
    logic [15:0] rep_reg;
    logic        anc_reg;
    logic        frag_reg;
    logic [15:0] sj_reg;
    logic [9:0]  rlen_reg;
    logic [5:0]  slot_reg;

    logic [6:0]    maxpw_reg;
    logic          aborted_reg;
    logic [CW-1:0] count_reg   [NUM_WINDOWS];
    logic [10:0]   minlen_reg  [NUM_WINDOWS];
    logic [7:0]    pieces_reg  [NUM_WINDOWS];
    logic [SW-1:0] lanchor_reg [NUM_WINDOWS];

    logic [CW-1:0] idx_reg;
    logic [CW-1:0] hit_reg;
    logic [CW-1:0] ins_reg;
    logic [CW-1:0] keep_reg;
    logic [10:0]   min_reg;

    logic        done_reg;
    logic [2:0]  status_reg;
    logic [5:0]  position_reg;
    logic [6:0]  count_out_reg;
    logic [7:0]  pieces_out_reg;
    logic [5:0]  lanchor_out_reg;
    entry_t      entry_out_reg;

    logic [WW-1:0] widx;
    logic [CW-1:0] cnt_w;
    logic [10:0]   minlen_w;
    logic [CW-1:0] idx_dn;
    logic [CW-1:0] idx_up;
    logic [SW-1:0] slot_sel;
    logic [AW-1:0] addr;
    entry_t        rd;
    entry_t        new_entry;
    entry_t        wdata;
    logic          keep_cond;
    logic          mem_we_eff;
    logic [8:0]    m9;
    logic [8:0]    emax9;
    logic [10:0]   rlen_p1;
    logic [40:0]   diag_new;
    logic [40:0]   diag_old;
    logic [10:0]   r_lo;
    logic [10:0]   r_hi;
    logic [10:0]   n_lo;
    logic [10:0]   n_hi;

    assign widx     = WW'(win_reg);
    assign cnt_w    = count_reg[widx];
    assign minlen_w = minlen_reg[widx];
    assign idx_dn   = idx_reg - 1'b1;
    assign idx_up   = idx_reg + 1'b1;
    assign rlen_p1  = 11'(rlen_reg) + 11'd1;

    assign new_entry = '{gs: gs_reg, sj: sj_reg, frag: frag_reg, anc: anc_reg,
                         rep: rep_reg, rs: rs_reg, len: len_reg};

    always_comb
    begin
        case (cmd.addr_sel)
            ADDR_IDX:    slot_sel = idx_reg[SW-1:0];
            ADDR_IDX_DN: slot_sel = idx_dn[SW-1:0];
            ADDR_IDX_UP: slot_sel = idx_up[SW-1:0];
            ADDR_INS:    slot_sel = ins_reg[SW-1:0];
            ADDR_KEEP:   slot_sel = keep_reg[SW-1:0];
            ADDR_SLOT:   slot_sel = SW'(slot_reg);
            default:     slot_sel = idx_reg[SW-1:0];
        endcase
    end

    assign addr  = AW'(widx) * AW'(SLOTS) + AW'(slot_sel);
    assign wdata = (cmd.wd_sel == WD_NEW) ? new_entry : rd;

    assign keep_cond  = rd.anc || (11'(rd.len) > min_reg);
    assign mem_we_eff = cmd.mem_we || (cmd.compact_step && keep_cond);

    swt_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_WINDOWS * SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we_eff),
        .waddr (addr),
        .wdata (wdata),
        .re    (cmd.mem_re),
        .raddr (addr),
        .rdata (rd)
    );

    assign m9    = 9'(maxpw_reg);
    assign emax9 = (m9 == 9'd0) ? 9'd1 : ((m9 > 9'(SLOTS)) ? 9'(SLOTS) : m9);

    assign diag_new = {1'b0, gs_reg} + 41'(rd.rs);
    assign diag_old = {1'b0, rd.gs} + 41'(rs_reg);
    assign r_lo     = 11'(rd.rs);
    assign r_hi     = 11'(rd.rs) + 11'(rd.len);
    assign n_lo     = 11'(rs_reg);
    assign n_hi     = 11'(rs_reg) + 11'(len_reg);

    always_comb
    begin
        sts.mode_new    = (mode_reg == MODE_NEW);
        sts.mode_assign = (mode_reg == MODE_ASSIGN);
        sts.mode_read   = (mode_reg == MODE_READ);
        sts.w_valid     = (9'(win_reg) < 9'(NUM_WINDOWS));
        sts.slot_out    = (9'(slot_reg) >= 9'(cnt_w));
        sts.aborted     = aborted_reg;
        sts.too_short   = !anc_reg && (11'(len_reg) < minlen_w);
        sts.cnt_zero    = (cnt_w == '0);
        sts.idx_last    = ((CW+1)'(idx_reg) + 1'b1) == (CW+1)'(cnt_w);
        sts.match       = (frag_reg == rd.frag) && (sj_reg == rd.sj)
                          && (diag_new == diag_old)
                          && (((n_lo >= r_lo) && (n_lo < r_hi))
                              || ((n_hi >= r_lo) && (n_hi < r_hi)));
        sts.longer      = (len_reg > rd.len);
        sts.rs_less     = (rs_reg < rd.rs);
        sts.ins_found   = (idx_reg != hit_reg) && (rs_reg < rd.rs);
        sts.full        = (9'(cnt_w) == emax9);
        sts.at_limit    = (9'(cnt_w) >= emax9);
        sts.min_none    = (min_reg == rlen_p1);
        sts.short_new   = !anc_reg && (11'(len_reg) < min_reg);
        sts.insert_ok   = anc_reg || (11'(len_reg) > minlen_w);
        sts.k_gt_ins    = (idx_reg > ins_reg);
        sts.k_lt_ins    = (idx_reg < ins_reg);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode;
            win_reg  <= window_index;
            gs_reg   <= genome_start;
            len_reg  <= align_length;
            rs_reg   <= read_start;
            rep_reg  <= repeat_count;
            anc_reg  <= is_anchor;
            frag_reg <= fragment;
            sj_reg   <= junction_id;
            rlen_reg <= read_length;
            slot_reg <= slot;
        end

        case (cmd.idx_op)
            IDX_HOLD: idx_reg <= idx_reg;
            IDX_ZERO: idx_reg <= '0;
            IDX_INC:  idx_reg <= idx_up;
            IDX_DEC:  idx_reg <= idx_dn;
            IDX_CNT:  idx_reg <= cnt_w;
            IDX_HIT:  idx_reg <= hit_reg;
            default:  idx_reg <= idx_reg;
        endcase

        if (cmd.hit_set)
        begin
            hit_reg <= idx_reg;
        end

        case (cmd.ins_op)
            INS_HOLD: ins_reg <= ins_reg;
            INS_IDX:  ins_reg <= idx_reg;
            INS_CNT:  ins_reg <= cnt_w;
            INS_ADJ:  ins_reg <= (ins_reg > hit_reg) ? ins_reg - 1'b1 : ins_reg;
            default:  ins_reg <= ins_reg;
        endcase

        case (cmd.min_op)
            MIN_HOLD: min_reg <= min_reg;
            MIN_INIT: min_reg <= rlen_p1;
            MIN_UPD:
            begin
                if (!rd.anc && (11'(rd.len) < min_reg))
                begin
                    min_reg <= 11'(rd.len);
                end
            end
            default:  min_reg <= min_reg;
        endcase

        if (cmd.keep_zero)
        begin
            keep_reg <= '0;
        end
        else if (cmd.compact_step && keep_cond)
        begin
            keep_reg <= keep_reg + 1'b1;
        end

        if (cmd.finish)
        begin
            status_reg <= cmd.fin_status;
            case (cmd.pos_sel)
                POS_NONE: position_reg <= '0;
                POS_SLOT: position_reg <= slot_reg;
                POS_HIT:  position_reg <= 6'(hit_reg);
                POS_INS:  position_reg <= 6'(ins_reg);
                default:  position_reg <= '0;
            endcase
            entry_out_reg   <= cmd.fin_entry ? rd : '0;
            count_out_reg   <= cmd.fin_fill ? 7'(cnt_w) : '0;
            pieces_out_reg  <= cmd.fin_fill ? pieces_reg[widx] : '0;
            lanchor_out_reg <= cmd.fin_fill ? 6'(lanchor_reg[widx]) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            maxpw_reg   <= MAX_PER_WINDOW_RESET;
            aborted_reg <= 1'b0;
            done_reg    <= 1'b0;
            for (int i = 0; i < NUM_WINDOWS; i++)
            begin
                count_reg[i]   <= '0;
                minlen_reg[i]  <= '0;
                pieces_reg[i]  <= '0;
                lanchor_reg[i] <= '0;
            end
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cfg_we)
            begin
                maxpw_reg <= cfg_wdata;
            end
            if (cmd.clear_all)
            begin
                aborted_reg <= 1'b0;
                for (int i = 0; i < NUM_WINDOWS; i++)
                begin
                    count_reg[i]   <= '0;
                    minlen_reg[i]  <= '0;
                    pieces_reg[i]  <= '0;
                    lanchor_reg[i] <= '0;
                end
            end
            if (cmd.set_abort)
            begin
                aborted_reg <= 1'b1;
            end
            if (cmd.min_commit)
            begin
                minlen_reg[widx] <= min_reg;
            end
            if (cmd.keep_commit)
            begin
                count_reg[widx] <= keep_reg;
                if (!anc_reg && (11'(len_reg) <= min_reg))
                begin
                    pieces_reg[widx] <= '0;
                end
            end
            if (cmd.insert_commit)
            begin
                count_reg[widx] <= cnt_w + 1'b1;
                if (pieces_reg[widx] != 8'hFF)
                begin
                    pieces_reg[widx] <= pieces_reg[widx] + 8'd1;
                end
                if (anc_reg && (lanchor_reg[widx] < ins_reg[SW-1:0]))
                begin
                    lanchor_reg[widx] <= ins_reg[SW-1:0];
                end
            end
        end
    end

    assign done               = done_reg;
    assign status             = status_reg;
    assign position           = position_reg;
    assign entry_count        = count_out_reg;
    assign piece_count        = pieces_out_reg;
    assign last_anchor        = lanchor_out_reg;
    assign entry_genome_start = entry_out_reg.gs;
    assign entry_length       = entry_out_reg.len;
    assign entry_read_start   = entry_out_reg.rs;
    assign entry_repeats      = entry_out_reg.rep;
    assign entry_anchor       = entry_out_reg.anc;
    assign entry_fragment     = entry_out_reg.frag;
    assign entry_junction     = entry_out_reg.sj;

endmodule

// File: rtl/swt_ctrl.sv
// Controller state machine: sequences scans, moves and commits.
// Depends on swt_pkg; talks to swt_datapath by command and status words.
module swt_ctrl
    import swt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [25:0] {
        S_IDLE     = 26'h0000001,
        S_DISPATCH = 26'h0000002,
        S_RD_DATA  = 26'h0000004,
        S_OV_RD    = 26'h0000008,
        S_OV_CMP   = 26'h0000010,
        S_HIT      = 26'h0000020,
        S_INS_RD   = 26'h0000040,
        S_INS_CMP  = 26'h0000080,
        S_ADJ      = 26'h0000100,
        S_SHIFT    = 26'h0000200,
        S_MVD_RD   = 26'h0000400,
        S_MVD_WR   = 26'h0000800,
        S_MVU_RD   = 26'h0001000,
        S_MVU_WR   = 26'h0002000,
        S_FIN_NEW  = 26'h0004000,
        S_FIN_OUT  = 26'h0008000,
        S_FULL_CHK = 26'h0010000,
        S_MIN_RD   = 26'h0020000,
        S_MIN_CMP  = 26'h0040000,
        S_MIN_DONE = 26'h0080000,
        S_CMP_RD   = 26'h0100000,
        S_CMP_CHK  = 26'h0200000,
        S_CMP_DONE = 26'h0400000,
        S_INS_CHK  = 26'h0800000,
        S_POS_RD   = 26'h1000000,
        S_POS_CMP  = 26'h2000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   insert_reg;
    logic   insert_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            insert_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            insert_reg <= insert_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        cmd         = '0;
        state_next  = state_reg;
        insert_next = insert_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                state_next = S_IDLE;
                if (sts.mode_new)
                begin
                    cmd.clear_all  = 1'b1;
                    cmd.finish     = 1'b1;
                    cmd.fin_status = ST_ACK;
                    cmd.pos_sel    = POS_NONE;
                end
                else if (!sts.mode_assign && !sts.mode_read)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = ST_ERROR;
                end
                else if (!sts.w_valid)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = ST_NOWIN;
                end
                else if (sts.mode_read)
                begin
                    if (sts.slot_out)
                    begin
                        cmd.finish     = 1'b1;
                        cmd.fin_status = ST_ERROR;
                        cmd.pos_sel    = POS_SLOT;
                        cmd.fin_fill   = 1'b1;
                    end
                    else
                    begin
                        cmd.mem_re   = 1'b1;
                        cmd.addr_sel = ADDR_SLOT;
                        state_next   = S_RD_DATA;
                    end
                end
                else if (sts.aborted)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = ST_ABORT;
                    cmd.fin_fill   = 1'b1;
                end
                else if (sts.too_short)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = ST_SHORT;
                    cmd.fin_fill   = 1'b1;
                end
                else if (sts.cnt_zero)
                begin
                    state_next = S_FULL_CHK;
                end
                else
                begin
                    cmd.idx_op = IDX_ZERO;
                    state_next = S_OV_RD;
                end
            end
            S_RD_DATA:
            begin
                cmd.finish     = 1'b1;
                cmd.fin_status = ST_ACK;
                cmd.pos_sel    = POS_SLOT;
                cmd.fin_entry  = 1'b1;
                cmd.fin_fill   = 1'b1;
                state_next     = S_IDLE;
            end
            S_OV_RD:
            begin
                cmd.mem_re   = 1'b1;
                cmd.addr_sel = ADDR_IDX;
                state_next   = S_OV_CMP;
            end
            S_OV_CMP:
            begin
                if (sts.match)
                begin
                    cmd.hit_set = 1'b1;
                    state_next  = S_HIT;
                end
                else if (sts.idx_last)
                begin
                    state_next = S_FULL_CHK;
                end
                else
                begin
                    cmd.idx_op = IDX_INC;
                    state_next = S_OV_RD;
                end
            end
            S_HIT:
            begin
                insert_next = 1'b0;
                if (sts.longer)
                begin
                    cmd.idx_op = IDX_ZERO;
                    state_next = S_INS_RD;
                end
                else
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = ST_KEPT;
                    cmd.pos_sel    = POS_HIT;
                    cmd.fin_fill   = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_INS_RD:
            begin
                cmd.mem_re   = 1'b1;
                cmd.addr_sel = ADDR_IDX;
                state_next   = S_INS_CMP;
            end
            S_INS_CMP:
            begin
                if (sts.ins_found)
                begin
                    cmd.ins_op = INS_IDX;
                    state_next = S_ADJ;
                end
                else if (sts.idx_last)
                begin
                    cmd.ins_op = INS_CNT;
                    state_next = S_ADJ;
                end
                else
                begin
                    cmd.idx_op = IDX_INC;
                    state_next = S_INS_RD;
                end
            end
            S_ADJ:
            begin
                cmd.ins_op = INS_ADJ;
                cmd.idx_op = IDX_HIT;
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                if (sts.k_gt_ins)
                begin
                    state_next = S_MVD_RD;
                end
                else if (sts.k_lt_ins)
                begin
                    state_next = S_MVU_RD;
                end
                else
                begin
                    state_next = S_FIN_NEW;
                end
            end
            S_MVD_RD:
            begin
                cmd.mem_re   = 1'b1;
                cmd.addr_sel = ADDR_IDX_DN;
                state_next   = S_MVD_WR;
            end
            S_MVD_WR:
            begin
                cmd.mem_we   = 1'b1;
                cmd.addr_sel = ADDR_IDX;
                cmd.wd_sel   = WD_RDATA;
                cmd.idx_op   = IDX_DEC;
                state_next   = S_SHIFT;
            end
            S_MVU_RD:
            begin
                cmd.mem_re   = 1'b1;
                cmd.addr_sel = ADDR_IDX_UP;
                state_next   = S_MVU_WR;
            end
            S_MVU_WR:
            begin
                cmd.mem_we   = 1'b1;
                cmd.addr_sel = ADDR_IDX;
                cmd.wd_sel   = WD_RDATA;
                cmd.idx_op   = IDX_INC;
                state_next   = S_SHIFT;
            end
            S_FIN_NEW:
            begin
                cmd.mem_we        = 1'b1;
                cmd.addr_sel      = ADDR_INS;
                cmd.wd_sel        = WD_NEW;
                cmd.insert_commit = insert_reg;
                state_next        = S_FIN_OUT;
            end
            S_FIN_OUT:
            begin
                cmd.finish     = 1'b1;
                cmd.fin_status = insert_reg ? ST_INS : ST_REPL;
                cmd.pos_sel    = POS_INS;
                cmd.fin_fill   = 1'b1;
                state_next     = S_IDLE;
            end
            S_FULL_CHK:
            begin
                if (sts.full)
                begin
                    cmd.idx_op = IDX_ZERO;
                    cmd.min_op = MIN_INIT;
                    state_next = S_MIN_RD;
                end
                else
                begin
                    state_next = S_INS_CHK;
                end
            end
            S_MIN_RD:
            begin
                cmd.mem_re   = 1'b1;
                cmd.addr_sel = ADDR_IDX;
                state_next   = S_MIN_CMP;
            end
            S_MIN_CMP:
            begin
                cmd.min_op = MIN_UPD;
                if (sts.idx_last)
                begin
                    state_next = S_MIN_DONE;
                end
                else
                begin
                    cmd.idx_op = IDX_INC;
                    state_next = S_MIN_RD;
                end
            end
            S_MIN_DONE:
            begin
                cmd.min_commit = 1'b1;
                if (sts.min_none)
                begin
                    cmd.set_abort  = 1'b1;
                    cmd.finish     = 1'b1;
                    cmd.fin_status = ST_ABORT;
                    cmd.fin_fill   = 1'b1;
                    state_next     = S_IDLE;
                end
                else if (sts.short_new)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = ST_SHORT;
                    cmd.fin_fill   = 1'b1;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.idx_op    = IDX_ZERO;
                    cmd.keep_zero = 1'b1;
                    state_next    = S_CMP_RD;
                end
            end
            S_CMP_RD:
            begin
                cmd.mem_re   = 1'b1;
                cmd.addr_sel = ADDR_IDX;
                state_next   = S_CMP_CHK;
            end
            S_CMP_CHK:
            begin
                cmd.compact_step = 1'b1;
                cmd.addr_sel     = ADDR_KEEP;
                cmd.wd_sel       = WD_RDATA;
                if (sts.idx_last)
                begin
                    state_next = S_CMP_DONE;
                end
                else
                begin
                    cmd.idx_op = IDX_INC;
                    state_next = S_CMP_RD;
                end
            end
            S_CMP_DONE:
            begin
                cmd.keep_commit = 1'b1;
                state_next      = S_INS_CHK;
            end
            S_INS_CHK:
            begin
                insert_next = 1'b1;
                if (!sts.insert_ok)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = ST_SHORT;
                    cmd.fin_fill   = 1'b1;
                    state_next     = S_IDLE;
                end
                else if (sts.at_limit)
                begin
                    cmd.finish     = 1'b1;
                    cmd.fin_status = ST_ERROR;
                    cmd.fin_fill   = 1'b1;
                    state_next     = S_IDLE;
                end
                else if (sts.cnt_zero)
                begin
                    cmd.ins_op = INS_CNT;
                    cmd.idx_op = IDX_CNT;
                    state_next = S_SHIFT;
                end
                else
                begin
                    cmd.idx_op = IDX_ZERO;
                    state_next = S_POS_RD;
                end
            end
            S_POS_RD:
            begin
                cmd.mem_re   = 1'b1;
                cmd.addr_sel = ADDR_IDX;
                state_next   = S_POS_CMP;
            end
            S_POS_CMP:
            begin
                if (sts.rs_less)
                begin
                    cmd.ins_op = INS_IDX;
                    cmd.idx_op = IDX_CNT;
                    state_next = S_SHIFT;
                end
                else if (sts.idx_last)
                begin
                    cmd.ins_op = INS_CNT;
                    cmd.idx_op = IDX_CNT;
                    state_next = S_SHIFT;
                end
                else
                begin
                    cmd.idx_op = IDX_INC;
                    state_next = S_POS_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/seed_window_table_top.sv
// Top level of the seed window table: controller plus datapath.
// Depends on swt_pkg, swt_ctrl, swt_datapath and the assertion macros.
//
//  channel   handshake         fields
//  command   start / busy      mode .. slot
//  result    done (1 cycle)    status .. entry_junction
//  config    cfg_we            cfg_wdata (max_per_window)
//
// New, no-window and bad-mode words end at dispatch; a read first reads RAM.
// An assign scans the window's entries in passes through the entry RAM
// (overlap, insert point after a hit, minimum, compaction, position) and
// moves entries one at a time, all over its single read port.
// Reset clears all window state at once; the entry RAM is not cleared.
// Results cannot be stalled; start is taken only while busy is low.
module seed_window_table_top
    import swt_pkg::*;
#(
    parameter int NUM_WINDOWS = NUM_WINDOWS_DEF,
    parameter int SLOTS       = SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    input  logic [1:0]  mode,
    input  logic [4:0]  window_index,
    input  logic [39:0] genome_start,
    input  logic [9:0]  align_length,
    input  logic [9:0]  read_start,
    input  logic [15:0] repeat_count,
    input  logic        is_anchor,
    input  logic        fragment,
    input  logic [15:0] junction_id,
    input  logic [9:0]  read_length,
    input  logic [5:0]  slot,
    output logic        done,
    output logic [2:0]  status,
    output logic [5:0]  position,
    output logic [6:0]  entry_count,
    output logic [7:0]  piece_count,
    output logic [5:0]  last_anchor,
    output logic [39:0] entry_genome_start,
    output logic [9:0]  entry_length,
    output logic [9:0]  entry_read_start,
    output logic [15:0] entry_repeats,
    output logic        entry_anchor,
    output logic        entry_fragment,
    output logic [15:0] entry_junction
);

    `include "seed_window_table_top_assert.svh"

    cmd_t cmd;
    sts_t sts;

    swt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .sts   (sts),
        .cmd   (cmd)
    );

    swt_datapath #(
        .NUM_WINDOWS (NUM_WINDOWS),
        .SLOTS       (SLOTS)
    ) u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .sts                (sts),
        .cfg_we             (cfg_we),
        .cfg_wdata          (cfg_wdata),
        .mode               (mode),
        .window_index       (window_index),
        .genome_start       (genome_start),
        .align_length       (align_length),
        .read_start         (read_start),
        .repeat_count       (repeat_count),
        .is_anchor          (is_anchor),
        .fragment           (fragment),
        .junction_id        (junction_id),
        .read_length        (read_length),
        .slot               (slot),
        .done               (done),
        .status             (status),
        .position           (position),
        .entry_count        (entry_count),
        .piece_count        (piece_count),
        .last_anchor        (last_anchor),
        .entry_genome_start (entry_genome_start),
        .entry_length       (entry_length),
        .entry_read_start   (entry_read_start),
        .entry_repeats      (entry_repeats),
        .entry_anchor       (entry_anchor),
        .entry_fragment     (entry_fragment),
        .entry_junction     (entry_junction)
    );

    `SWT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
    `SWT_ASSERT_NEXT(a_done_single, done, !done, "result strobe longer than one cycle")
    `SWT_ASSERT_NOW(a_fall_done, $fell(busy), done, "busy dropped without a result")
    `SWT_ASSERT_NOW(a_done_idle, done, !busy && $past(busy), "result outside end of a word")

endmodule
